[rtl/gsrc_pkg.sv]
// Package: frame state record, result record, codes and the CRC-8 byte update.
`timescale 1ns / 1ps

package gsrc_pkg;

   localparam logic [7:0]  CRC_POLY    = 8'h31;
   localparam logic [7:0]  CRC_INIT    = 8'hFF;
   localparam logic [7:0]  CRC_MSB     = 8'h80;
   localparam logic [15:0] SELFTEST_OK = 16'hD400;

   localparam logic KIND_MEASUREMENT = 1'b0;
   localparam logic KIND_SELFTEST    = 1'b1;

   // Frame positions: data high, data low, check byte of group one, then group two
   localparam logic [2:0] POS_G1_HIGH  = 3'd0;
   localparam logic [2:0] POS_G1_LOW   = 3'd1;
   localparam logic [2:0] POS_G1_CHECK = 3'd2;
   localparam logic [2:0] POS_G2_HIGH  = 3'd3;
   localparam logic [2:0] POS_G2_LOW   = 3'd4;
   localparam logic [2:0] POS_G2_CHECK = 3'd5;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_CRC_MISMATCH = 2'd1,
      STATUS_SELFTEST_BAD = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]  byte_position;
      logic [7:0]  running_crc;
      logic        crc_failed;
      logic [7:0]  high_byte_latch;
      logic [7:0]  low_byte_latch;
      logic [15:0] first_word_store;
   } frame_state_type;

   typedef struct packed {
      logic [15:0] first_word;
      logic [15:0] second_word;
      status_type  status;
   } result_type;

   localparam frame_state_type STATE_RESET = '{
      byte_position:    3'd0,
      running_crc:      CRC_INIT,
      crc_failed:       1'b0,
      high_byte_latch:  8'd0,
      low_byte_latch:   8'd0,
      first_word_store: 16'd0
   };

   // Fold one byte into the CRC, MSB first
   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_MSB) != 8'd0) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

[rtl/gsrc_channels.sv]
// Interfaces: received-byte channel and frame-result channel.
`timescale 1ns / 1ps

interface gsrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface gsrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] first_word;
   logic [15:0] second_word;
   logic [1:0]  status;

   modport source (output valid, output first_word, output second_word, output status,
                   input ready);
   modport sink   (input valid, input first_word, input second_word, input status,
                   output ready);
endinterface

[rtl/gsrc_state_mem.sv]
// Single-entry frame state memory with registered read and write-through.
`timescale 1ns / 1ps

module gsrc_state_mem (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  gsrc_pkg::frame_state_type wr_data,
   output gsrc_pkg::frame_state_type rd_data
);
   import gsrc_pkg::*;

   frame_state_type state_mem [0:0];
   logic            valid_ff;
   frame_state_type rd_ff;

   // Write the entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[0] <= wr_data;
      end
   end

   // Mark the entry written; before that it reads as the reset record
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff <= 1'b1;
      end
   end

   // Register the read, forward a same-edge write
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= STATE_RESET;
      end else if (wr_en) begin
         rd_ff <= wr_data;
      end else if (valid_ff) begin
         rd_ff <= state_mem[0];
      end else begin
         rd_ff <= STATE_RESET;
      end
   end

   assign rd_data = rd_ff;

endmodule

[rtl/gsrc_frame_step.sv]
// Per-byte update of the frame state: CRC, word assembly and result decision.
`timescale 1ns / 1ps

module gsrc_frame_step (
   input  gsrc_pkg::frame_state_type cur_state,
   input  logic [7:0]                rx_byte,
   input  logic                      frame_start,
   input  logic                      response_kind,
   output gsrc_pkg::frame_state_type next_state,
   output logic                      res_valid,
   output gsrc_pkg::result_type      result
);
   import gsrc_pkg::*;

   logic [2:0]  pos;
   logic        failed;
   logic [15:0] word;

   // Restart on frame start or an out-of-range position
   always_comb begin
      pos = frame_start ? POS_G1_HIGH : cur_state.byte_position;
      if (pos > POS_G2_CHECK) begin
         pos = POS_G1_HIGH;
      end
      failed = (pos == POS_G1_HIGH) ? 1'b0 : cur_state.crc_failed;
   end

   assign word = {cur_state.high_byte_latch, cur_state.low_byte_latch};

   // Advance the state and decide whether the frame ends here
   always_comb begin
      next_state            = cur_state;
      next_state.crc_failed = failed;
      res_valid             = 1'b0;
      result.first_word     = cur_state.first_word_store;
      result.second_word    = 16'd0;
      result.status         = STATUS_OK;
      case (pos)
         POS_G1_HIGH, POS_G2_HIGH: begin
            next_state.running_crc     = crc_byte(CRC_INIT, rx_byte);
            next_state.high_byte_latch = rx_byte;
            next_state.byte_position   = pos + 3'd1;
         end
         POS_G1_LOW, POS_G2_LOW: begin
            next_state.running_crc    = crc_byte(cur_state.running_crc, rx_byte);
            next_state.low_byte_latch = rx_byte;
            next_state.byte_position  = pos + 3'd1;
         end
         default: begin
            // Check byte
            if (cur_state.running_crc != rx_byte) begin
               next_state.crc_failed = 1'b1;
            end
            if (pos == POS_G1_CHECK) begin
               next_state.first_word_store = word;
            end
            if (pos == POS_G1_CHECK && response_kind == KIND_MEASUREMENT) begin
               next_state.byte_position = POS_G2_HIGH;
            end else begin
               res_valid                = 1'b1;
               next_state.byte_position = POS_G1_HIGH;
               result.first_word        = next_state.first_word_store;
               if (pos == POS_G2_CHECK && response_kind == KIND_MEASUREMENT) begin
                  result.second_word = word;
               end
               if (next_state.crc_failed) begin
                  result.status = STATUS_CRC_MISMATCH;
               end else if (response_kind == KIND_SELFTEST &&
                            next_state.first_word_store != SELFTEST_OK) begin
                  result.status = STATUS_SELFTEST_BAD;
               end
            end
         end
      endcase
   end

endmodule

[rtl/gas_sensor_response_checker.sv]
// Path: a frame's last check byte is registered in the byte stage, its result in the
//   result register. Throughput: one byte per cycle unless results stall; the frame
//   state is one memory entry with a registered read that forwards same-edge writes.
// Reset: synchronous, active high; the state entry reads as its reset record until
//   first written, the response kind returns to measurement and both stages empty.
`timescale 1ns / 1ps

module gas_sensor_response_checker (
   input  logic       clock,
   input  logic       reset,
   gsrc_req_if.sink   req_chan,
   gsrc_rsp_if.source rsp_chan,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);
   import gsrc_pkg::*;

   logic            kind_ff;
   logic            s1_v_ff, s1_v_in;
   logic [7:0]      s1_byte_ff;
   logic            s1_start_ff;
   logic            out_v_ff, out_v_in;
   result_type      out_res_ff, out_res_in;
   logic            s1_go;
   logic            req_take;
   logic            res_valid;
   result_type      step_res;
   frame_state_type cur_state, next_state;

   // Hold the response kind
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_MEASUREMENT;
      end else if (csr_write_enable) begin
         kind_ff <= csr_write_data;
      end
   end

   assign s1_go         = s1_v_ff && (!out_v_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_v_ff || s1_go;
   assign req_take      = req_chan.valid && req_chan.ready;

   gsrc_state_mem u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (s1_go),
      .wr_data (next_state),
      .rd_data (cur_state)
   );

   gsrc_frame_step u_frame_step (
      .cur_state     (cur_state),
      .rx_byte       (s1_byte_ff),
      .frame_start   (s1_start_ff),
      .response_kind (kind_ff),
      .next_state    (next_state),
      .res_valid     (res_valid),
      .result        (step_res)
   );

   // Advance the byte stage and the result register
   always_comb begin
      s1_v_in = s1_v_ff;
      if (req_take) begin
         s1_v_in = 1'b1;
      end else if (s1_go) begin
         s1_v_in = 1'b0;
      end
      out_v_in   = out_v_ff;
      out_res_in = out_res_ff;
      if (s1_go && res_valid) begin
         out_v_in   = 1'b1;
         out_res_in = step_res;
      end else if (rsp_chan.ready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // Capture the beat payloads
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff  <= req_chan.rx_byte;
         s1_start_ff <= req_chan.frame_start;
      end
      out_res_ff <= out_res_in;
   end

   assign rsp_chan.valid       = out_v_ff;
   assign rsp_chan.first_word  = out_res_ff.first_word;
   assign rsp_chan.second_word = out_res_ff.second_word;
   assign rsp_chan.status      = out_res_ff.status;

   // A frame ends only on a check byte
   a_result_on_check: assert property (@(posedge clock) disable iff (reset)
      (s1_go && res_valid) |-> (s1_start_ff == 1'b0 &&
         (cur_state.byte_position == POS_G1_CHECK ||
          cur_state.byte_position == POS_G2_CHECK)))
      else $error("result issued off a check byte");

   // Stored position stays inside the frame
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |-> (cur_state.byte_position <= POS_G2_CHECK))
      else $error("frame position out of range");

   // Input stalls only behind a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_v_ff && out_v_ff && !rsp_chan.ready))
      else $error("input stalled without cause");

   // A passing self-test carries the expected word
   a_selftest_ok: assert property (@(posedge clock) disable iff (reset)
      (s1_go && res_valid && kind_ff == KIND_SELFTEST && step_res.status == STATUS_OK)
      |=> (rsp_chan.first_word == SELFTEST_OK && rsp_chan.valid))
      else $error("self-test passed with wrong word");

endmodule

[tb/gas_sensor_response_checker_test.sv]
// Testbench for the gas sensor response checker: directed frames, then random frames.
`timescale 1ns / 1ps

module gas_sensor_response_checker_test;
   import gsrc_pkg::*;

   localparam int RANDOM_ITEMS = 1150;
   localparam int CALM_AFTER   = 1000;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 4;

   typedef struct {
      logic        set_kind;
      logic        kind;
      logic [7:0]  rx_byte;
      logic        frame_start;
      logic        known;
      logic [15:0] first_word;
      logic [15:0] second_word;
      status_type  status;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   gsrc_req_if req_bus ();
   gsrc_rsp_if rsp_bus ();

   gas_sensor_response_checker uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Frame results still owed by the block, oldest first
   result_type expected_frames[$];
   int mismatch_count = 0;
   int cycle_count    = 0;
   int random_items   = 0;

   // Idling controls for the sender and the receiver
   int src_gap_pct    = 0;
   int sink_stall_pct = 0;
   bit calm           = 1'b0;
   bit hold_off_request = 1'b0;

   // Predicted frame state
   logic        model_kind;
   logic [2:0]  model_pos;
   logic [7:0]  model_crc;
   logic        model_failed;
   logic [7:0]  model_high;
   logic [7:0]  model_low;
   logic [15:0] model_first;

   logic [7:0] frame_bytes [6];
   stim_row_type directed_rows [27];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Fold one byte into a CRC-8, MSB first
   function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

   // Advance the predicted frame state by one byte; return 1 when a frame result is due
   function automatic bit track_frame(input logic [7:0] b, input logic start,
                                      output result_type frame);
      logic [2:0]  p;
      logic [15:0] word;
      frame = '0;
      if (start) begin
         model_pos = POS_G1_HIGH;
      end
      p = model_pos;
      if (p > POS_G2_CHECK) begin
         p = POS_G1_HIGH;
      end
      if (p == POS_G1_HIGH) begin
         model_failed = 1'b0;
      end
      if (p == POS_G1_HIGH || p == POS_G2_HIGH) begin
         model_crc  = crc8_fold(CRC_INIT, b);
         model_high = b;
         model_pos  = p + 3'd1;
         return 1'b0;
      end
      if (p == POS_G1_LOW || p == POS_G2_LOW) begin
         model_crc = crc8_fold(model_crc, b);
         model_low = b;
         model_pos = p + 3'd1;
         return 1'b0;
      end
      // Check byte
      if (model_crc != b) begin
         model_failed = 1'b1;
      end
      word = {model_high, model_low};
      if (p == POS_G1_CHECK) begin
         model_first = word;
         if (model_kind == KIND_MEASUREMENT) begin
            model_pos = POS_G2_HIGH;
            return 1'b0;
         end
      end
      frame.first_word  = model_first;
      frame.second_word = (p == POS_G2_CHECK && model_kind == KIND_MEASUREMENT) ? word : 16'd0;
      if (model_failed) begin
         frame.status = STATUS_CRC_MISMATCH;
      end else if (model_kind == KIND_SELFTEST && model_first != SELFTEST_OK) begin
         frame.status = STATUS_SELFTEST_BAD;
      end else begin
         frame.status = STATUS_OK;
      end
      model_pos = POS_G1_HIGH;
      return 1'b1;
   endfunction

   // Offer one byte beat, with an optional idle burst first; return once it is taken
   task automatic send_beat(input logic [7:0] b, input logic s);
      int gap;
      if (!calm && $urandom_range(0, 99) < src_gap_pct) begin
         gap = $urandom_range(1, 18);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.rx_byte     <= b;
      req_bus.frame_start <= s;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Send a byte and record the frame result it predicts, if any
   task automatic feed_byte(input logic [7:0] b, input logic s);
      result_type frame;
      send_beat(b, s);
      if (track_frame(b, s, frame)) begin
         expected_frames.push_back(frame);
      end
      random_items++;
   endtask

   // Drop valid and let every owed result and the pipeline drain
   task automatic drain_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_response_kind(input logic kind);
      drain_block();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= kind;
      model_kind = kind;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Fill a two-group frame, mostly with good check bytes
   task automatic build_frame();
      logic [15:0] w;
      logic [7:0]  c;
      for (int g = 0; g < 2; g++) begin
         case ($urandom_range(0, 15))
            0, 1:    w = SELFTEST_OK;
            2:       w = 16'h0000;
            3:       w = 16'hFFFF;
            default: w = 16'($urandom_range(0, 65535));
         endcase
         c = crc8_fold(crc8_fold(CRC_INIT, w[15:8]), w[7:0]);
         if ($urandom_range(0, 99) < 10) begin
            c = c ^ 8'($urandom_range(1, 255));
         end
         frame_bytes[3*g]   = w[15:8];
         frame_bytes[3*g+1] = w[7:0];
         frame_bytes[3*g+2] = c;
      end
   endtask

   // Cycle budget
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, one long hold-off on request
   initial begin
      int stall;
      int hold_count;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_bus.ready <= 1'b0;
            for (hold_count = 1; hold_count < HOLD_CYCLES; hold_count++) @(negedge clock);
            hold_off_request = 1'b0;
         end else if (!calm && $urandom_range(0, 99) < sink_stall_pct) begin
            stall = $urandom_range(1, 18);
            rsp_bus.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare each result beat with the oldest owed result
   always @(posedge clock) begin
      result_type owed;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_frames.size() == 0) begin
            $error("unexpected result: first_word %h second_word %h status %0d",
                   rsp_bus.first_word, rsp_bus.second_word, rsp_bus.status);
            mismatch_count++;
         end else begin
            owed = expected_frames.pop_front();
            if (rsp_bus.first_word !== owed.first_word) begin
               $error("first_word: expected %h, got %h", owed.first_word, rsp_bus.first_word);
               mismatch_count++;
            end
            if (rsp_bus.second_word !== owed.second_word) begin
               $error("second_word: expected %h, got %h", owed.second_word,
                      rsp_bus.second_word);
               mismatch_count++;
            end
            if (rsp_bus.status !== owed.status) begin
               $error("status: expected %0d, got %0d", owed.status, rsp_bus.status);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      result_type frame;
      result_type typed;
      bit         produced;
      bit         force_start;
      int         carry_len;
      int         phase;
      int         phase_end;
      int         roll;
      int         flen;
      int         n;

      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_write_data      = 1'b0;
      req_bus.valid       = 1'b0;
      req_bus.rx_byte     = 8'd0;
      req_bus.frame_start = 1'b0;
      model_kind   = KIND_MEASUREMENT;
      model_pos    = POS_G1_HIGH;
      model_crc    = CRC_INIT;
      model_failed = 1'b0;
      model_high   = 8'd0;
      model_low    = 8'd0;
      model_first  = 16'd0;

      // set_kind, kind, byte, start, known, first_word, second_word, status
      directed_rows = '{
         // measurement after reset, both groups good
         '{1'b0, 1'b0, 8'hBE, 1'b1, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'hEF, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'h92, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'hBE, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'hEF, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'h92, 1'b0, 1'b1, 16'hBEEF, 16'hBEEF, STATUS_OK},
         // next frame with no start flag, byte extremes, then dropped mid-frame
         '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         // restart; bad check byte in group one only
         '{1'b0, 1'b0, 8'hBE, 1'b1, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'hEF, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'hBE, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'hEF, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'h92, 1'b0, 1'b1, 16'hBEEF, 16'hBEEF, STATUS_CRC_MISMATCH},
         // self-test, good word
         '{1'b1, 1'b1, 8'hD4, 1'b1, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'hC6, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         // self-test, bad check byte wins over bad word
         '{1'b0, 1'b0, 8'hBE, 1'b1, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'hEF, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'hFF, 1'b0, 1'b1, 16'hBEEF, 16'h0000, STATUS_CRC_MISMATCH},
         // kind switched to measurement before the group-one check byte
         '{1'b0, 1'b0, 8'hD4, 1'b1, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b1, 1'b0, 8'hC6, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK},
         '{1'b0, 1'b0, 8'hFF, 1'b0, 1'b0, 16'h0, 16'h0, STATUS_OK}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_kind) begin
            write_response_kind(directed_rows[i].kind);
         end
         send_beat(directed_rows[i].rx_byte, directed_rows[i].frame_start);
         produced = track_frame(directed_rows[i].rx_byte, directed_rows[i].frame_start, frame);
         if (directed_rows[i].known) begin
            typed.first_word  = directed_rows[i].first_word;
            typed.second_word = directed_rows[i].second_word;
            typed.status      = directed_rows[i].status;
            expected_frames.push_back(typed);
         end else if (produced) begin
            expected_frames.push_back(frame);
         end
      end

      // Random phases, each under its own response kind and idling mix
      random_items = 0;
      carry_len    = 0;
      force_start  = 1'b0;
      phase        = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= CALM_AFTER) begin
            calm = 1'b1;
         end
         write_response_kind(1'($urandom_range(0, 1)));
         case ($urandom_range(0, 2))
            0:       src_gap_pct = 0;
            1:       src_gap_pct = 15;
            default: src_gap_pct = 50;
         endcase
         case ($urandom_range(0, 2))
            0:       sink_stall_pct = 0;
            1:       sink_stall_pct = 15;
            default: sink_stall_pct = 50;
         endcase
         if (phase == 1) begin
            hold_off_request = 1'b1;
         end

         // Finish a frame split across the kind change
         for (int j = 6 - carry_len; j < 6; j++) begin
            feed_byte(frame_bytes[j], 1'b0);
         end
         carry_len = 0;

         phase_end = random_items + $urandom_range(30, 150);
         while (random_items < phase_end) begin
            roll = $urandom_range(0, 99);
            flen = (model_kind == KIND_SELFTEST) ? 3 : 6;
            build_frame();
            if (roll < 8) begin
               // noise bytes
               n = $urandom_range(1, 7);
               repeat (n) feed_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
               force_start = 1'b1;
            end else if (roll < 14) begin
               // truncated frame, dropped by the next start
               n = $urandom_range(1, flen - 1);
               for (int j = 0; j < n; j++) begin
                  feed_byte(frame_bytes[j], j == 0);
               end
               force_start = 1'b1;
            end else begin
               for (int j = 0; j < flen; j++) begin
                  feed_byte(frame_bytes[j],
                            j == 0 && (force_start || $urandom_range(0, 3) != 0));
               end
               force_start = 1'b0;
            end
         end

         // Leave a frame open across the next register write
         if ($urandom_range(0, 2) == 0) begin
            build_frame();
            n = $urandom_range(1, 5);
            for (int j = 0; j < n; j++) begin
               feed_byte(frame_bytes[j], j == 0);
            end
            carry_len = 6 - n;
         end
         phase++;
      end

      // Drain and finish
      calm = 1'b1;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/gsrc_pkg.sv
rtl/gsrc_channels.sv
rtl/gsrc_state_mem.sv
rtl/gsrc_frame_step.sv
rtl/gas_sensor_response_checker.sv
tb/gas_sensor_response_checker_test.sv
